// File: hw/rtl/skf_pkg.sv
// scalar kalman filter package: widths, constants, register indexes,
// controller state type and the command and status structs
// used by skf_ctrl, skf_datapath and scalar_kalman_filter_core
package skf_pkg;

   // widths of the fixed fields
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int FIELD_WIDTH        = 32;
   localparam int CFG_WIDTH          = 32;
   localparam int GAIN_WIDTH         = 17;
   localparam int FRAC_BITS          = 16;
   localparam int DIV_STEPS          = 16;
   localparam int CNT_WIDTH          = $clog2(DIV_STEPS);
   localparam int CSR_INDEX_WIDTH    = 2;

   // fixed point constants
   localparam logic [GAIN_WIDTH-1:0] GAIN_ONE   = 17'h10000;
   localparam logic [FRAC_BITS-1:0]  ROUND_HALF = 16'h8000;
   localparam logic [CFG_WIDTH-1:0]  NOISE_RESET = 32'h0001_0000;

   // configuration register indexes
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_PROCESS_NOISE     = 2'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MEASUREMENT_NOISE = 2'd1;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_DIV,
      ST_EST_LO,
      ST_EST_HI,
      ST_COV_LO,
      ST_COV_HI,
      ST_DONE
   } state_type;

   // commands from controller to datapath
   typedef struct packed {
      logic load;      // take the item, form predicted covariance
      logic prep;      // form divisor and innovation, seed the divider
      logic div_step;  // one restoring division step
      logic mul_en;    // one pass of the shared multiplier
      logic mul_hi;    // upper half of the operand, else lower half
      logic mul_cov;   // covariance product, else estimate product
      logic commit;    // update state and load the output register
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic gain_one;  // gain is exactly 1.0, no division needed
      logic out_free;  // output register can take a new item
   } status_type;

endpackage

// File: hw/rtl/skf_ctrl.sv
// scalar kalman filter controller: sequences predict, divide,
// multiply and commit for each item; uses skf_pkg
module skf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  skf_pkg::status_type  status,
   output skf_pkg::cmd_type     cmd
);
   import skf_pkg::*;

   state_type              state_ff;
   state_type              state_in;
   logic [CNT_WIDTH-1:0]   cnt_ff;
   logic [CNT_WIDTH-1:0]   cnt_in;

   // state and step counter
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            cmd.prep = 1'b1;
            cnt_in   = '0;
            state_in = status.gain_one ? ST_EST_LO : ST_DIV;
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            cnt_in       = CNT_WIDTH'(cnt_ff + 1'b1);
            if (cnt_ff == CNT_WIDTH'(DIV_STEPS - 1)) begin
               state_in = ST_EST_LO;
            end
         end
         ST_EST_LO: begin
            cmd.mul_en = 1'b1;
            state_in   = ST_EST_HI;
         end
         ST_EST_HI: begin
            cmd.mul_en = 1'b1;
            cmd.mul_hi = 1'b1;
            state_in   = ST_COV_LO;
         end
         ST_COV_LO: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_cov = 1'b1;
            state_in    = ST_COV_HI;
         end
         ST_COV_HI: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_hi  = 1'b1;
            cmd.mul_cov = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// File: hw/rtl/skf_datapath.sv
// scalar kalman filter datapath: noise registers, filter state,
// restoring gain divider, shared multiplier and output register; uses skf_pkg
module skf_datapath #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  skf_pkg::cmd_type                     cmd,
   output skf_pkg::status_type                  status,
   input  logic                                 csr_write,
   input  logic [skf_pkg::CSR_INDEX_WIDTH-1:0]  csr_index,
   input  logic [skf_pkg::CFG_WIDTH-1:0]        csr_data,
   input  logic signed [skf_pkg::FIELD_WIDTH-1:0] req_measurement,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [skf_pkg::FIELD_WIDTH-1:0] rsp_estimate,
   output logic [skf_pkg::GAIN_WIDTH-1:0]       rsp_gain
);
   import skf_pkg::*;

   localparam int W    = DATA_WIDTH;
   localparam int ZW   = (W > FIELD_WIDTH) ? W : FIELD_WIDTH;
   localparam int SW   = ZW + 1;
   localparam int RW   = SW + 1;
   localparam int MAGW = W + 1;
   localparam int HIW  = MAGW - FRAC_BITS;
   localparam int MW   = (HIW > FRAC_BITS) ? HIW : FRAC_BITS;
   localparam int PW   = MW + GAIN_WIDTH;
   localparam int EW   = W + 2;

   localparam logic [ZW-1:0] EMAX_Z = {{(ZW - W + 1){1'b0}}, {(W - 1){1'b1}}};
   localparam logic [ZW-1:0] EMIN_Z = ~EMAX_Z;
   localparam logic [EW-1:0] EMAX_E = {3'b000, {(W - 1){1'b1}}};
   localparam logic [EW-1:0] EMIN_E = ~EMAX_E;

   // registers
   logic [CFG_WIDTH-1:0]   q_ff, q_in, r_ff, r_in;
   logic [W-1:0]           est_ff, est_in, cov_ff, cov_in;
   logic [W-1:0]           z_ff, z_in, pm_ff, pm_in;
   logic [SW-1:0]          div_ff, div_in;
   logic [RW-1:0]          rem_ff, rem_in;
   logic [GAIN_WIDTH-1:0]  gain_ff, gain_in;
   logic [MAGW-1:0]        mag_ff, mag_in, delta_ff, delta_in;
   logic                   neg_ff, neg_in;
   logic [GAIN_WIDTH-1:0]  acc_ff, acc_in;
   logic [W-1:0]           covn_ff, covn_in;
   logic                   out_valid_ff, out_valid_in;
   logic [FIELD_WIDTH-1:0] out_est_ff, out_est_in;
   logic [GAIN_WIDTH-1:0]  out_gain_ff, out_gain_in;

   // combinational helpers
   logic [ZW-1:0]          meas_ext, z_sat;
   logic [SW-1:0]          pm_sum;
   logic [W-1:0]           pm_sat;
   logic [MAGW-1:0]        innov;
   logic [RW-1:0]          rem_shift;
   logic [MAGW-1:0]        mul_src;
   logic [MW-1:0]          mul_a;
   logic [GAIN_WIDTH-1:0]  mul_b;
   logic [PW-1:0]          prod, prod_round, prod_sum;
   logic [EW-1:0]          est_sum, delta_ext;
   logic [W-1:0]           est_next;
   logic [ZW-1:0]          est_wide;

   // measurement clamped to the estimate range
   always_comb begin
      meas_ext = ZW'(req_measurement);
      if ($signed(meas_ext) > $signed(EMAX_Z)) begin
         z_sat = EMAX_Z;
      end else if ($signed(meas_ext) < $signed(EMIN_Z)) begin
         z_sat = EMIN_Z;
      end else begin
         z_sat = meas_ext;
      end
   end

   // predicted covariance, saturating
   always_comb begin
      pm_sum = SW'(cov_ff) + SW'(q_ff);
      pm_sat = (|pm_sum[SW-1:W]) ? '1 : pm_sum[W-1:0];
   end

   // innovation and restoring divider step
   always_comb begin
      innov     = {z_ff[W-1], z_ff} - {est_ff[W-1], est_ff};
      rem_shift = {rem_ff[RW-2:0], 1'b0};
   end

   // shared multiplier, operand split into low and high halves
   always_comb begin
      mul_src    = cmd.mul_cov ? MAGW'(pm_ff) : mag_ff;
      mul_a      = cmd.mul_hi ? MW'(mul_src[MAGW-1:FRAC_BITS])
                              : MW'(mul_src[FRAC_BITS-1:0]);
      mul_b      = cmd.mul_cov ? (GAIN_ONE - gain_ff) : gain_ff;
      prod       = PW'(mul_a) * PW'(mul_b);
      prod_round = prod + PW'(ROUND_HALF);
      prod_sum   = prod + PW'(acc_ff);
   end

   // new estimate, saturated to the signed state range
   always_comb begin
      delta_ext = neg_ff ? (EW'(0) - EW'(delta_ff)) : EW'(delta_ff);
      est_sum   = EW'($signed(est_ff)) + delta_ext;
      if ($signed(est_sum) > $signed(EMAX_E)) begin
         est_next = EMAX_E[W-1:0];
      end else if ($signed(est_sum) < $signed(EMIN_E)) begin
         est_next = EMIN_E[W-1:0];
      end else begin
         est_next = est_sum[W-1:0];
      end
      est_wide = ZW'($signed(est_next));
   end

   // next values
   always_comb begin
      q_in        = q_ff;
      r_in        = r_ff;
      est_in      = est_ff;
      cov_in      = cov_ff;
      z_in        = z_ff;
      pm_in       = pm_ff;
      div_in      = div_ff;
      rem_in      = rem_ff;
      gain_in     = gain_ff;
      mag_in      = mag_ff;
      neg_in      = neg_ff;
      acc_in      = acc_ff;
      delta_in    = delta_ff;
      covn_in     = covn_ff;
      out_est_in  = out_est_ff;
      out_gain_in = out_gain_ff;

      // configuration writes, unknown indexes ignored
      if (csr_write) begin
         case (csr_index)
            CSR_PROCESS_NOISE:     q_in = csr_data;
            CSR_MEASUREMENT_NOISE: r_in = csr_data;
            default: ;
         endcase
      end

      if (cmd.load) begin
         z_in  = z_sat[W-1:0];
         pm_in = pm_sat;
      end

      if (cmd.prep) begin
         div_in  = SW'(pm_ff) + SW'(r_ff);
         rem_in  = RW'(pm_ff);
         gain_in = status.gain_one ? GAIN_ONE : '0;
         neg_in  = innov[MAGW-1];
         mag_in  = innov[MAGW-1] ? (MAGW'(0) - innov) : innov;
      end

      if (cmd.div_step) begin
         if (rem_shift >= RW'(div_ff)) begin
            rem_in  = rem_shift - RW'(div_ff);
            gain_in = {gain_ff[GAIN_WIDTH-2:0], 1'b1};
         end else begin
            rem_in  = rem_shift;
            gain_in = {gain_ff[GAIN_WIDTH-2:0], 1'b0};
         end
      end

      if (cmd.mul_en) begin
         if (!cmd.mul_hi) begin
            acc_in = prod_round[FRAC_BITS +: GAIN_WIDTH];
         end else if (cmd.mul_cov) begin
            covn_in = prod_sum[W-1:0];
         end else begin
            delta_in = prod_sum[MAGW-1:0];
         end
      end

      if (cmd.commit) begin
         est_in      = est_next;
         cov_in      = covn_ff;
         out_est_in  = est_wide[FIELD_WIDTH-1:0];
         out_gain_in = gain_ff;
      end

      // output register handshake
      if (cmd.commit) begin
         out_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   // state and output valid cleared, noise registers set to NOISE_RESET at reset
   always_ff @(posedge clock) begin
      if (reset) begin
         q_ff         <= NOISE_RESET;
         r_ff         <= NOISE_RESET;
         est_ff       <= '0;
         cov_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         q_ff         <= q_in;
         r_ff         <= r_in;
         est_ff       <= est_in;
         cov_ff       <= cov_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      z_ff        <= z_in;
      pm_ff       <= pm_in;
      div_ff      <= div_in;
      rem_ff      <= rem_in;
      gain_ff     <= gain_in;
      mag_ff      <= mag_in;
      neg_ff      <= neg_in;
      acc_ff      <= acc_in;
      delta_ff    <= delta_in;
      covn_ff     <= covn_in;
      out_est_ff  <= out_est_in;
      out_gain_ff <= out_gain_in;
   end

   // zero measurement noise makes the divisor equal the dividend,
   // and a zero divisor needs it too: both give a gain of 1.0
   assign status.gain_one = (r_ff == '0);
   assign status.out_free = !out_valid_ff || !rsp_stall;

   assign rsp_valid    = out_valid_ff;
   assign rsp_estimate = out_est_ff;
   assign rsp_gain     = out_gain_ff;

endmodule

// File: hw/rtl/scalar_kalman_filter_core.sv
// Scalar Kalman filter core (A = H = 1): one estimate per measurement item,
// Q16.16 data, Q1.16 gain. For each item the covariance is predicted on
// acceptance, then the divisor and innovation are formed, then sixteen steps
// of the restoring gain divider and four passes of the shared multiplier (low
// and high halves of the estimate and covariance products) run, then a commit.
// With zero measurement noise the divider is skipped. The input is taken
// again in the cycle after the commit, so a new item can enter while the
// previous result still waits in the output register; the commit waits only
// if that register is still full and stalled. Configuration writes are always
// ready and must be made while no item is in flight.
module scalar_kalman_filter_core #(
   parameter int DATA_WIDTH = skf_pkg::DATA_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic signed [skf_pkg::FIELD_WIDTH-1:0] req_measurement,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [skf_pkg::FIELD_WIDTH-1:0] rsp_estimate,
   output logic [skf_pkg::GAIN_WIDTH-1:0]         rsp_gain,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic [skf_pkg::CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [skf_pkg::CFG_WIDTH-1:0]          csr_data
);
   import skf_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   // sequencer
   skf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // arithmetic and state
   skf_datapath #(
      .DATA_WIDTH (DATA_WIDTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write       (csr_valid && csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_estimate    (rsp_estimate),
      .rsp_gain        (rsp_gain)
   );

   // an accepted item blocks the input until it is committed
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken again straight after an item");

   // the gain never exceeds 1.0
   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain <= GAIN_ONE)
      else $error("gain above 1.0");

   // a new result only appears from a commit, while the input is blocked
   a_result_from_commit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without an item in flight");

endmodule

// File: dv/tb.sv
`timescale 1ns / 100ps
// testbench for scalar_kalman_filter_core: directed and random measurement items
// checked against an in-bench fixed point predictor; depends on skf_pkg and the core
module tb;
   import skf_pkg::*;

   localparam int DW        = DATA_WIDTH_DEFAULT;
   localparam int TAIL_WAIT = 40;
   localparam int MAX_SHOWN = 10;

   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_A = 2'd2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_UNMAPPED_B = 2'd3;

   localparam logic signed [63:0] EST_MAX = (64'sd1 <<< (DW - 1)) - 64'sd1;
   localparam logic signed [63:0] EST_MIN = -EST_MAX - 64'sd1;
   localparam logic [63:0]        COV_MAX = (64'd1 << DW) - 64'd1;

   typedef struct packed {
      logic [FIELD_WIDTH-1:0] estimate;
      logic [GAIN_WIDTH-1:0]  gain;
   } kf_result_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic signed [FIELD_WIDTH-1:0] req_measurement = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic signed [FIELD_WIDTH-1:0] rsp_estimate;
   logic [GAIN_WIDTH-1:0]         rsp_gain;
   logic                          csr_valid = 1'b0;
   logic                          csr_ready;
   logic [CSR_INDEX_WIDTH-1:0]    csr_index = '0;
   logic [CFG_WIDTH-1:0]          csr_data = '0;

   // predictor state and register copies
   logic signed [63:0]   est_q16 = '0;
   logic [63:0]          cov_q16 = '0;
   logic [CFG_WIDTH-1:0] q_noise = NOISE_RESET;
   logic [CFG_WIDTH-1:0] r_noise = NOISE_RESET;

   kf_result_type pending_estimates[$];
   kf_result_type oldest;
   int            mismatches = 0;

   // sender bookkeeping
   logic [FIELD_WIDTH-1:0] offered_sample = '0;
   logic                   sample_on_offer = 1'b0;
   int                     send_idle_pct = 30;
   int                     stall_pct = 30;
   int                     stall_hold = 0;

   scalar_kalman_filter_core dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_measurement (req_measurement),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_estimate    (rsp_estimate),
      .rsp_gain        (rsp_gain),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   always #1 clock = ~clock;

   // give up on a hung run
   initial begin
      #2000000;
      $display("end of test: mismatches");
      $finish;
   end

   // mostly short gaps, now and then a long one
   function automatic int idle_len(int pct);
      int pick;
      if ($urandom_range(0, 99) >= pct) return 0;
      pick = $urandom_range(0, 19);
      if (pick < 15) return $urandom_range(1, 3);
      if (pick < 19) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   // round(mag * g / 2^16), halves upwards on the magnitude
   function automatic logic [63:0] round_scale(logic [63:0] mag, logic [63:0] g);
      return (mag >> FRAC_BITS) * g
             + (((mag & 64'hFFFF) * g + {48'd0, ROUND_HALF}) >> FRAC_BITS);
   endfunction

   // restoring division for the gain fraction, 1.0 when the divisor is zero or not larger
   function automatic logic [GAIN_WIDTH-1:0] gain_divide(logic [63:0] pm, logic [63:0] dv);
      logic [63:0]           rem;
      logic [GAIN_WIDTH-1:0] quo;
      int                    i;
      if (dv == 64'd0 || pm >= dv) return GAIN_ONE;
      rem = pm;
      quo = '0;
      for (i = 0; i < DIV_STEPS; i++) begin
         rem = rem << 1;
         quo = quo << 1;
         if (rem >= dv) begin
            rem = rem - dv;
            quo[0] = 1'b1;
         end
      end
      return quo;
   endfunction

   // one filter step: predict, gain, estimate update, covariance update
   function automatic kf_result_type kf_update(logic signed [FIELD_WIDTH-1:0] sample);
      logic signed [63:0] z;
      logic signed [63:0] innov;
      logic signed [63:0] delta;
      logic [63:0]        pm;
      logic [63:0]        g;
      kf_result_type      res;
      z = sample;
      if (z > EST_MAX) z = EST_MAX;
      if (z < EST_MIN) z = EST_MIN;
      pm = cov_q16 + {32'd0, q_noise};
      if (pm > COV_MAX) pm = COV_MAX;
      g = {47'd0, gain_divide(pm, pm + {32'd0, r_noise})};
      innov = z - est_q16;
      if (innov >= 0) delta = round_scale(innov, g);
      else delta = -round_scale(-innov, g);
      est_q16 = est_q16 + delta;
      if (est_q16 > EST_MAX) est_q16 = EST_MAX;
      if (est_q16 < EST_MIN) est_q16 = EST_MIN;
      cov_q16 = round_scale(pm, {47'd0, GAIN_ONE} - g);
      if (cov_q16 > COV_MAX) cov_q16 = COV_MAX;
      res.estimate = est_q16[FIELD_WIDTH-1:0];
      res.gain     = g[GAIN_WIDTH-1:0];
      return res;
   endfunction

   // receiver stall pattern: stretches of stall and of flow
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold != 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         rsp_stall  <= ($urandom_range(0, 99) < stall_pct);
         stall_hold <= idle_len(100);
      end
   end

   task automatic log_mismatch(input string why, input kf_result_type want,
                               input kf_result_type got);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
         $display("%0t %s: estimate %h gain %h, expected estimate %h gain %h",
                  $time, why, got.estimate, got.gain, want.estimate, want.gain);
   endtask

   // result checker: each item against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_estimates.size() == 0) begin
            log_mismatch("unexpected item", '0, {rsp_estimate, rsp_gain});
         end else begin
            oldest = pending_estimates.pop_front();
            if (rsp_estimate !== oldest.estimate || rsp_gain !== oldest.gain)
               log_mismatch("wrong item", oldest, {rsp_estimate, rsp_gain});
         end
      end
   end

   // wait for the offered item to go in and record its expectation
   task automatic take_offer();
      do @(posedge clock); while (!(req_valid && !req_stall));
      pending_estimates.push_back(kf_update(offered_sample));
   endtask

   task automatic send_sample(input logic [FIELD_WIDTH-1:0] sample);
      int gap;
      gap = idle_len(send_idle_pct);
      if (sample_on_offer) take_offer();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_measurement <= sample;
      offered_sample  = sample;
      sample_on_offer = 1'b1;
   endtask

   task automatic flush_sender();
      if (sample_on_offer) begin
         take_offer();
         req_valid <= 1'b0;
         sample_on_offer = 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      flush_sender();
      while (pending_estimates.size() != 0) @(posedge clock);
   endtask

   // register write, only with the core idle
   task automatic csr_write(input logic [CSR_INDEX_WIDTH-1:0] idx,
                            input logic [CFG_WIDTH-1:0] value);
      wait_drained();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      csr_valid <= 1'b0;
      case (idx)
         CSR_PROCESS_NOISE:     q_noise = value;
         CSR_MEASUREMENT_NOISE: r_noise = value;
         default: ;
      endcase
      @(posedge clock);
   endtask

   // reset noise values, extremes of the measurement
   task automatic test_reset_state();
      send_sample(32'h0000_0000);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      send_sample(32'h0000_0001);
      send_sample(32'hFFFF_FFFF);
   endtask

   // writes to unmapped indexes leave both noise values alone
   task automatic test_unmapped_index();
      csr_write(CSR_UNMAPPED_A, 32'h0000_0000);
      csr_write(CSR_UNMAPPED_B, 32'hFFFF_FFFF);
      send_sample(32'h0012_3456);
      send_sample(32'hFFF0_0000);
   endtask

   // zero measurement noise, then zero divisor, then zero gain
   task automatic test_zero_noise();
      csr_write(CSR_MEASUREMENT_NOISE, 32'h0000_0000);
      csr_write(CSR_PROCESS_NOISE, 32'hFFFF_FFFF);
      send_sample(32'h7FFF_FFFF);
      send_sample(32'h8000_0000);
      csr_write(CSR_PROCESS_NOISE, 32'h0000_0000);
      send_sample(32'h0001_8000);
      send_sample(32'hFFFE_0000);
      csr_write(CSR_MEASUREMENT_NOISE, 32'hFFFF_FFFF);
      send_sample(32'h4000_0000);
      send_sample(32'hC000_0000);
   endtask

   // covariance growth up to its ceiling
   task automatic test_covariance_ceiling();
      csr_write(CSR_PROCESS_NOISE, 32'hFFFF_FFFF);
      send_sample(32'h0100_0000);
      send_sample(32'hFF00_0000);
      send_sample(32'h7FFF_FFFF);
   endtask

   // half gain on odd innovations: halves round away from zero
   task automatic test_rounding_halves();
      int                     k;
      logic [FIELD_WIDTH-1:0] probes[3];
      probes[0] = 32'h0000_0001;
      probes[1] = 32'hFFFF_FFFF;
      probes[2] = 32'h0000_0003;
      for (k = 0; k < 3; k++) begin
         csr_write(CSR_MEASUREMENT_NOISE, 32'h0000_0000);
         send_sample(32'h0000_0000);
         csr_write(CSR_PROCESS_NOISE, NOISE_RESET);
         csr_write(CSR_MEASUREMENT_NOISE, NOISE_RESET);
         send_sample(probes[k]);
      end
   endtask

   function automatic logic [CFG_WIDTH-1:0] pick_noise();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return $urandom_range(1, 255);
         3:       return NOISE_RESET;
         4, 5:    return $urandom_range(1, 32'h0010_0000);
         default: return $urandom;
      endcase
   endfunction

   // sensor-like samples around a target, with extremes and raw noise mixed in
   function automatic logic [FIELD_WIDTH-1:0] pick_measurement(int target);
      int span;
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 3))
               0:       return 32'h7FFF_FFFF;
               1:       return 32'h8000_0000;
               2:       return 32'h0000_0000;
               default: return 32'hFFFF_FFFF;
            endcase
         end
         1, 2:    return $urandom;
         default: begin
            span = 1 << $urandom_range(4, 20);
            return target + int'($urandom_range(0, 2 * span)) - span;
         end
      endcase
   endfunction

   // random noise settings, each with a run of random samples
   task automatic test_random_phases();
      int phase;
      int n;
      int target;
      for (phase = 0; phase < 11; phase++) begin
         csr_write(CSR_PROCESS_NOISE, pick_noise());
         csr_write(CSR_MEASUREMENT_NOISE, pick_noise());
         if (phase % 4 == 2) begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end else begin
            send_idle_pct = $urandom_range(10, 60);
            stall_pct     = $urandom_range(10, 60);
         end
         target = $urandom;
         for (n = 0; n < 50; n++) begin
            if ($urandom_range(0, 39) == 0) wait_drained();
            if ($urandom_range(0, 15) == 0) target = $urandom;
            send_sample(pick_measurement(target));
         end
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_unmapped_index();
      test_zero_noise();
      test_covariance_ceiling();
      test_rounding_halves();
      test_random_phases();
      wait_drained();
      repeat (TAIL_WAIT) @(posedge clock);
      if (mismatches == 0 && pending_estimates.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
